// File: hdl/pfac_pkg.sv
// ----------------------------------------------------------------------------
// pfac_pkg
// Types and constants for the polygon fan area and centroid block.
// ----------------------------------------------------------------------------
package pfac_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int AREA_WIDTH  = 32;
   localparam int MUL_A_WIDTH = COORD_WIDTH + 1;
   localparam int MUL_B_WIDTH = AREA_WIDTH;
   localparam int MUL_P_WIDTH = MUL_A_WIDTH + MUL_B_WIDTH;
   localparam int THIRD_SHIFT = COORD_WIDTH + 4;

   localparam logic [MUL_B_WIDTH-1:0] THIRD_MULT =
      MUL_B_WIDTH'(((64'd1 << THIRD_SHIFT) + 64'd2) / 64'd3);
   localparam logic [AREA_WIDTH-1:0] AREA_MAX = '1;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] vertex_x;
      logic signed [COORD_WIDTH-1:0] vertex_y;
      logic                          first_vertex;
   } req_type;

   typedef struct packed {
      logic [AREA_WIDTH-1:0]         area_total;
      logic signed [COORD_WIDTH-1:0] centroid_x;
      logic signed [COORD_WIDTH-1:0] centroid_y;
      logic                          area_saturated;
   } rsp_type;

endpackage

// File: hdl/polygon_fan_area_centroid.sv
// ----------------------------------------------------------------------------
// polygon_fan_area_centroid
// Running polygon area and centroid over a fan of triangles, one vertex per item.
// ----------------------------------------------------------------------------
// Each vertex item gives one result with the running area and centroid.
// A first or second vertex of a polygon goes from IDLE straight to PUSH, which
// loads its result into the output register. A later vertex passes MUL_P, MUL_Q
// and AREA; if its fan triangle and running area are both zero it then goes to
// PUSH. Every other later vertex goes on through TCX, TCY, BLX, DIVX, BLY, DIVY
// and FIXY before PUSH: a sequencer drives one shared 17 x 32 multiplier for the
// cross products, the divisions by three and the blend products, and one
// restoring divider used for each centroid axis in turn. After PUSH the
// block returns to IDLE to accept the next item. It takes no new item until
// the result is loaded into the output register, so every cycle that the
// output stays stalled with a result waiting adds to the time for the item.
module polygon_fan_area_centroid (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pfac_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pfac_pkg::rsp_type rsp_data
);
   import pfac_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int CW = $clog2(W);

   typedef enum logic [3:0] {
      IDLE, MUL_P, MUL_Q, AREA, TCX, TCY, BLX, DIVX, BLY, DIVY, FIXY, PUSH
   } state_type;

   state_type                 state_ff;
   logic signed [W-1:0]       anchor_x_ff, anchor_y_ff, prior_x_ff, prior_y_ff;
   logic signed [W-1:0]       vx_ff, vy_ff, center_x_ff, center_y_ff;
   logic signed [W-1:0]       tcx_ff, tcy_ff;
   logic [1:0]                seen_ff;
   logic [AREA_WIDTH-1:0]     area_sum_ff, t_ff;
   logic [AREA_WIDTH:0]       den_ff, rem_ff;
   logic [MUL_P_WIDTH-1:0]    prod_ff;
   logic [2*W+1:0]            mp_ff;
   logic [W-1:0]              dq_ff;
   logic [CW-1:0]             cnt_ff;
   logic                      neg_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff;

   logic signed [W:0]         dx1, dy1, dx2, dy2;
   logic [W:0]                mdx1, mdy1, mdx2, mdy2;
   logic [2*W+1:0]            mq;
   logic                      sp, sq;
   logic [2*W+2:0]            twice;
   logic [2*W+1:0]            t_full;
   logic [AREA_WIDTH-1:0]     t_in;
   logic [AREA_WIDTH:0]       den_in;
   logic signed [W+1:0]       sum_x, sum_y;
   logic [W:0]                n_x, n_y;
   logic [W-1:0]              q_x, q_y;
   logic signed [W-1:0]       tc_x_in, tc_y_in;
   logic signed [W:0]         diff_x, diff_y;
   logic [W:0]                mdiff_x, mdiff_y;
   logic [MUL_A_WIDTH-1:0]    mul_a;
   logic [MUL_B_WIDTH-1:0]    mul_b;
   logic [MUL_P_WIDTH-1:0]    mul_p;
   logic [AREA_WIDTH+1:0]     rem_sh;
   logic                      rem_ge;
   logic                      rnd_up;
   logic [W:0]                q_rnd;
   logic signed [W-1:0]       center_in;
   logic [AREA_WIDTH-1:0]     area_in;

   assign dx1  = $signed({prior_x_ff[W-1], prior_x_ff}) - $signed({anchor_x_ff[W-1], anchor_x_ff});
   assign dy1  = $signed({prior_y_ff[W-1], prior_y_ff}) - $signed({anchor_y_ff[W-1], anchor_y_ff});
   assign dx2  = $signed({vx_ff[W-1], vx_ff}) - $signed({anchor_x_ff[W-1], anchor_x_ff});
   assign dy2  = $signed({vy_ff[W-1], vy_ff}) - $signed({anchor_y_ff[W-1], anchor_y_ff});
   assign mdx1 = dx1[W] ? (W+1)'(-dx1) : (W+1)'(dx1);
   assign mdy1 = dy1[W] ? (W+1)'(-dy1) : (W+1)'(dy1);
   assign mdx2 = dx2[W] ? (W+1)'(-dx2) : (W+1)'(dx2);
   assign mdy2 = dy2[W] ? (W+1)'(-dy2) : (W+1)'(dy2);

   assign mq     = prod_ff[2*W+1:0];
   assign sp     = (dx1[W] != dy2[W]) && (mp_ff != '0);
   assign sq     = (dy1[W] != dx2[W]) && (mq != '0);
   assign twice  = (sp != sq) ? {1'b0, mp_ff} + {1'b0, mq}
                 : (mp_ff >= mq) ? {1'b0, mp_ff - mq} : {1'b0, mq - mp_ff};
   assign t_full = twice[2*W+2:1] + (2*W+2)'(twice[0]);
   assign t_in   = (t_full > (2*W+2)'(AREA_MAX)) ? AREA_MAX : AREA_WIDTH'(t_full);
   assign den_in = {1'b0, area_sum_ff} + {1'b0, t_in};

   assign sum_x  = $signed({{2{anchor_x_ff[W-1]}}, anchor_x_ff})
                 + $signed({{2{prior_x_ff[W-1]}}, prior_x_ff})
                 + $signed({{2{vx_ff[W-1]}}, vx_ff});
   assign sum_y  = $signed({{2{anchor_y_ff[W-1]}}, anchor_y_ff})
                 + $signed({{2{prior_y_ff[W-1]}}, prior_y_ff})
                 + $signed({{2{vy_ff[W-1]}}, vy_ff});
   assign n_x    = (W+1)'(sum_x[W+1] ? -sum_x : sum_x) + (W+1)'(1);
   assign n_y    = (W+1)'(sum_y[W+1] ? -sum_y : sum_y) + (W+1)'(1);
   assign q_x    = W'(prod_ff >> THIRD_SHIFT);
   assign q_y    = W'(prod_ff >> THIRD_SHIFT);
   assign tc_x_in = sum_x[W+1] ? -$signed(q_x) : $signed(q_x);
   assign tc_y_in = sum_y[W+1] ? -$signed(q_y) : $signed(q_y);

   assign diff_x  = $signed({tcx_ff[W-1], tcx_ff}) - $signed({center_x_ff[W-1], center_x_ff});
   assign diff_y  = $signed({tcy_ff[W-1], tcy_ff}) - $signed({center_y_ff[W-1], center_y_ff});
   assign mdiff_x = diff_x[W] ? (W+1)'(-diff_x) : (W+1)'(diff_x);
   assign mdiff_y = diff_y[W] ? (W+1)'(-diff_y) : (W+1)'(diff_y);

   always_comb begin
      mul_a = mdx1;
      mul_b = MUL_B_WIDTH'(mdy2);
      case (state_ff)
         MUL_P: begin
            mul_a = mdx1;
            mul_b = MUL_B_WIDTH'(mdy2);
         end
         MUL_Q: begin
            mul_a = mdy1;
            mul_b = MUL_B_WIDTH'(mdx2);
         end
         AREA: begin
            mul_a = n_x;
            mul_b = THIRD_MULT;
         end
         TCX: begin
            mul_a = n_y;
            mul_b = THIRD_MULT;
         end
         BLX: begin
            mul_a = mdiff_x;
            mul_b = t_ff;
         end
         BLY: begin
            mul_a = mdiff_y;
            mul_b = t_ff;
         end
         default: begin
            mul_a = mdx1;
            mul_b = MUL_B_WIDTH'(mdy2);
         end
      endcase
   end

   assign mul_p = MUL_P_WIDTH'(mul_a) * MUL_P_WIDTH'(mul_b);

   assign rem_sh    = {rem_ff, dq_ff[W-1]};
   assign rem_ge    = rem_sh >= {1'b0, den_ff};
   assign rnd_up    = rem_ff >= (den_ff - rem_ff);
   assign q_rnd     = {1'b0, dq_ff} + (W+1)'(rnd_up);
   assign center_in = neg_ff ? W'($signed({center_x_ff[W-1], center_x_ff}) - $signed(q_rnd))
                             : W'($signed({center_x_ff[W-1], center_x_ff}) + $signed(q_rnd));
   assign area_in   = den_in[AREA_WIDTH] ? AREA_MAX : den_in[AREA_WIDTH-1:0];

   logic signed [W-1:0] center_y_in;
   assign center_y_in = neg_ff ? W'($signed({center_y_ff[W-1], center_y_ff}) - $signed(q_rnd))
                               : W'($signed({center_y_ff[W-1], center_y_ff}) + $signed(q_rnd));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         seen_ff      <= '0;
         area_sum_ff  <= '0;
         anchor_x_ff  <= '0;
         anchor_y_ff  <= '0;
         prior_x_ff   <= '0;
         prior_y_ff   <= '0;
         center_x_ff  <= '0;
         center_y_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != PUSH) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  vx_ff <= req_data.vertex_x;
                  vy_ff <= req_data.vertex_y;
                  if (req_data.first_vertex || seen_ff == 2'd0) begin
                     anchor_x_ff <= req_data.vertex_x;
                     anchor_y_ff <= req_data.vertex_y;
                     prior_x_ff  <= req_data.vertex_x;
                     prior_y_ff  <= req_data.vertex_y;
                     area_sum_ff <= '0;
                     center_x_ff <= '0;
                     center_y_ff <= '0;
                     seen_ff     <= 2'd1;
                     state_ff    <= PUSH;
                  end else if (seen_ff == 2'd1) begin
                     prior_x_ff <= req_data.vertex_x;
                     prior_y_ff <= req_data.vertex_y;
                     seen_ff    <= 2'd2;
                     state_ff   <= PUSH;
                  end else begin
                     state_ff <= MUL_P;
                  end
               end
            end
            MUL_P: begin
               prod_ff  <= mul_p;
               state_ff <= MUL_Q;
            end
            MUL_Q: begin
               mp_ff    <= prod_ff[2*W+1:0];
               prod_ff  <= mul_p;
               state_ff <= AREA;
            end
            AREA: begin
               t_ff        <= t_in;
               den_ff      <= den_in;
               area_sum_ff <= area_in;
               seen_ff     <= 2'd3;
               prod_ff     <= mul_p;
               state_ff    <= (den_in == '0) ? PUSH : TCX;
               if (den_in == '0) begin
                  prior_x_ff <= vx_ff;
                  prior_y_ff <= vy_ff;
               end
            end
            TCX: begin
               tcx_ff   <= tc_x_in;
               prod_ff  <= mul_p;
               state_ff <= TCY;
            end
            TCY: begin
               tcy_ff     <= tc_y_in;
               prior_x_ff <= vx_ff;
               prior_y_ff <= vy_ff;
               state_ff   <= BLX;
            end
            BLX: begin
               rem_ff   <= (AREA_WIDTH+1)'(mul_p >> W);
               dq_ff    <= mul_p[W-1:0];
               neg_ff   <= diff_x[W];
               cnt_ff   <= CW'(W - 1);
               state_ff <= DIVX;
            end
            DIVX: begin
               rem_ff <= rem_ge ? (AREA_WIDTH+1)'(rem_sh - {1'b0, den_ff})
                                : rem_sh[AREA_WIDTH:0];
               dq_ff  <= {dq_ff[W-2:0], rem_ge};
               cnt_ff <= cnt_ff - CW'(1);
               if (cnt_ff == '0) begin
                  state_ff <= BLY;
               end
            end
            BLY: begin
               center_x_ff <= center_in;
               rem_ff      <= (AREA_WIDTH+1)'(mul_p >> W);
               dq_ff       <= mul_p[W-1:0];
               neg_ff      <= diff_y[W];
               cnt_ff      <= CW'(W - 1);
               state_ff    <= DIVY;
            end
            DIVY: begin
               rem_ff <= rem_ge ? (AREA_WIDTH+1)'(rem_sh - {1'b0, den_ff})
                                : rem_sh[AREA_WIDTH:0];
               dq_ff  <= {dq_ff[W-2:0], rem_ge};
               cnt_ff <= cnt_ff - CW'(1);
               if (cnt_ff == '0) begin
                  state_ff <= FIXY;
               end
            end
            FIXY: begin
               center_y_ff <= center_y_in;
               state_ff    <= PUSH;
            end
            PUSH: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff.area_total     <= area_sum_ff;
                  rsp_ff.centroid_x     <= center_x_ff;
                  rsp_ff.centroid_y     <= center_y_ff;
                  rsp_ff.area_saturated <= (area_sum_ff == AREA_MAX);
                  rsp_valid_ff          <= 1'b1;
                  state_ff              <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_div_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIVX || state_ff == DIVY) |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");

   a_area_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == AREA) |=> (area_sum_ff >= $past(area_sum_ff)))
      else $error("area total decreased within a polygon");

   a_no_polygon_no_area: assert property (@(posedge clock) disable iff (reset)
      (seen_ff == 2'd0) |-> (area_sum_ff == '0))
      else $error("area present before any polygon started");

   a_push_from_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == PUSH && !rsp_stall) |=> (rsp_valid_ff && state_ff == IDLE))
      else $error("result not loaded when output was free");
`endif

endmodule
